// ===== rtl/bhlc_pkg.sv =====
// Shared types and constants for the button hold-level classifier.
// No dependencies; imported by button_hold_level_classifier_unit.

package bhlc_pkg;

   // input item kinds
   localparam logic [1:0] FUNC_POLL     = 2'd0;
   localparam logic [1:0] FUNC_STOP     = 2'd1;
   localparam logic [1:0] FUNC_ACTIVITY = 2'd2;

   // event codes
   localparam logic [2:0] EV_RELEASE   = 3'd0;
   localparam logic [2:0] EV_PRESS     = 3'd1;
   localparam logic [2:0] EV_SHORT     = 3'd2;
   localparam logic [2:0] EV_LONG      = 3'd3;
   localparam logic [2:0] EV_VERYLONG  = 3'd4;
   localparam logic [2:0] EV_SUPERLONG = 3'd5;

   // hold levels
   localparam logic [3:0] LVL_NONE      = 4'd0;
   localparam logic [3:0] LVL_SHORT     = 4'd2;
   localparam logic [3:0] LVL_LONG      = 4'd3;
   localparam logic [3:0] LVL_VERYLONG  = 4'd4;
   localparam logic [3:0] LVL_SUPERLONG = 4'd5;
   localparam logic [3:0] LVL_STOPPED   = 4'd10;

   // button numbers and active-button codes (code = button + 1, zero = none)
   localparam logic [1:0] BTN_ALT  = 2'd1;
   localparam logic [1:0] BTN_UP   = 2'd2;
   localparam logic [2:0] ACT_NONE = 3'd0;

   // register indexes
   localparam logic [2:0] CSR_SHORT_HOLD     = 3'd0;
   localparam logic [2:0] CSR_LONG_HOLD      = 3'd1;
   localparam logic [2:0] CSR_VERYLONG_HOLD  = 3'd2;
   localparam logic [2:0] CSR_SUPERLONG_HOLD = 3'd3;
   localparam logic [2:0] CSR_SLOW_REPEAT    = 3'd4;
   localparam logic [2:0] CSR_FAST_REPEAT    = 3'd5;
   localparam logic [2:0] CSR_DEBOUNCE       = 3'd6;
   localparam logic [2:0] CSR_ALT_PRESENT    = 3'd7;

   // register reset values
   localparam logic [15:0] SHORT_HOLD_RST     = 16'd1000;
   localparam logic [15:0] LONG_HOLD_RST      = 16'd3000;
   localparam logic [15:0] VERYLONG_HOLD_RST  = 16'd5000;
   localparam logic [15:0] SUPERLONG_HOLD_RST = 16'd10000;
   localparam logic [15:0] SLOW_REPEAT_RST    = 16'd125;
   localparam logic [15:0] FAST_REPEAT_RST    = 16'd20;
   localparam logic [15:0] DEBOUNCE_RST       = 16'd150;

   // one result event
   typedef struct packed {
      logic [1:0] button;
      logic [2:0] event_res;
      logic [3:0] prior_level;
   } bhlc_event_type;

endpackage

// ===== rtl/button_hold_level_classifier_unit.sv =====
// Button hold-level classifier with auto-repeat, top level.
// Depends on bhlc_pkg for event, level and register codes.
//
//  port group  dir  beat contents (low bits first)
//  req_*       in   tdata: now_ms[31:0], pressed[35:32]; tuser: func
//  rsp_*       out  tdata: button[1:0], event_res[4:2], prior_level[8:5]; tlast: last
//  csr_*       in   write enable, register index, 16-bit write data
//
// An item is registered on entry and classified combinationally against the state.
// Its events (up to four) are loaded into a four-entry result buffer and leave
// one per cycle while rsp is ready; the buffer drain is the limit, and the next
// item is classified as the last event leaves. Items with no events pass at one per cycle.
// A stall on rsp holds the buffer; one more item waits in the input register.
// Synchronous reset clears state and valid flags and loads the register reset values; no clearing pass.

module button_hold_level_classifier_unit
   import bhlc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // now_ms[31:0], pressed[35:32], zero fill
   input  logic [1:0]  req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // button[1:0], event_res[4:2], prior_level[8:5]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   // configuration registers
   logic [15:0] short_hold_ff, long_hold_ff, verylong_hold_ff, superlong_hold_ff;
   logic [15:0] slow_repeat_ff, fast_repeat_ff, debounce_ff;
   logic        alt_present_ff;

   // classifier state
   logic [2:0]  active_ff, active_in;
   logic [3:0]  hold_ff, hold_in;
   logic [31:0] activity_ff, activity_in;
   logic [31:0] repeat_ff, repeat_in;

   // input register
   logic        in_vld_ff;
   logic [1:0]  in_func_ff;
   logic [31:0] in_now_ff;
   logic [3:0]  in_pressed_ff;

   // result buffer
   bhlc_event_type ev_ff [4];
   logic [2:0]  rem_ff;
   logic [1:0]  rd_ff;

   // classifier signals
   logic           proc;
   logic [31:0]    elapsed, rep_elapsed;
   logic           debounced;
   bhlc_event_type ev_list [4];
   logic [2:0]     ev_n;
   bhlc_event_type cur_ev;

   // config write port
   always_ff @(posedge clock) begin
      if (reset) begin
         short_hold_ff     <= SHORT_HOLD_RST;
         long_hold_ff      <= LONG_HOLD_RST;
         verylong_hold_ff  <= VERYLONG_HOLD_RST;
         superlong_hold_ff <= SUPERLONG_HOLD_RST;
         slow_repeat_ff    <= SLOW_REPEAT_RST;
         fast_repeat_ff    <= FAST_REPEAT_RST;
         debounce_ff       <= DEBOUNCE_RST;
         alt_present_ff    <= 1'b1;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SHORT_HOLD:     short_hold_ff     <= csr_wdata;
            CSR_LONG_HOLD:      long_hold_ff      <= csr_wdata;
            CSR_VERYLONG_HOLD:  verylong_hold_ff  <= csr_wdata;
            CSR_SUPERLONG_HOLD: superlong_hold_ff <= csr_wdata;
            CSR_SLOW_REPEAT:    slow_repeat_ff    <= csr_wdata;
            CSR_FAST_REPEAT:    fast_repeat_ff    <= csr_wdata;
            CSR_DEBOUNCE:       debounce_ff       <= csr_wdata;
            CSR_ALT_PRESENT:    alt_present_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // handshake: classify when the buffer is empty or handing out its last beat
   assign proc       = in_vld_ff && (rem_ff == 3'd0 || (rem_ff == 3'd1 && rsp_tready));
   assign req_tready = !in_vld_ff || proc;
   assign rsp_tvalid = rem_ff != 3'd0;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_func_ff    <= req_tuser;
         in_now_ff     <= req_tdata[31:0];
         in_pressed_ff <= req_tdata[35:32];
      end
   end

   // wrapping time differences; activity difference serves debounce and hold
   assign elapsed     = in_now_ff - activity_ff;
   assign rep_elapsed = in_now_ff - repeat_ff;
   assign debounced   = elapsed < {16'd0, debounce_ff};

   // classify one item: stop, activity, or a poll with release, press, hold level, auto-repeat
   always_comb begin
      logic [3:0]  en, down, elig;
      logic [1:0]  act_idx, press_idx, tgt_idx;
      logic        have_act, rel, held, press, tgt_vld;
      logic [3:0]  hl0, hl1;
      logic [31:0] el, rdiff;
      logic [2:0]  hold_code;
      logic        hold_fire, short_fire, rep_fire;
      logic [15:0] rate;

      active_in   = active_ff;
      hold_in     = hold_ff;
      activity_in = activity_ff;
      repeat_in   = repeat_ff;
      ev_n        = 3'd0;
      for (int i = 0; i < 4; i++) ev_list[i] = '0;

      en       = 4'b1111;
      en[BTN_ALT] = alt_present_ff;
      down     = in_pressed_ff & en;
      have_act = active_ff != ACT_NONE;
      act_idx  = 2'(active_ff - 3'd1);
      rel      = have_act && en[act_idx] && !in_pressed_ff[act_idx];
      held     = have_act && en[act_idx] && in_pressed_ff[act_idx];

      // a new press: first enabled pressed button, after a released one
      for (int b = 0; b < 4; b++) begin
         elig[b] = down[b] && (!have_act || (rel && 2'(b) > act_idx));
      end
      press     = elig != 4'd0;
      press_idx = elig[0] ? 2'd0 : elig[1] ? 2'd1 : elig[2] ? 2'd2 : 2'd3;

      // hold level of the button that stays down after this poll
      tgt_vld = press || held;
      tgt_idx = press ? press_idx : act_idx;
      hl0     = press ? LVL_NONE : hold_ff;
      el      = press ? 32'd0 : elapsed;
      hold_fire  = 1'b0;
      short_fire = 1'b0;
      hold_code  = EV_SHORT;
      hl1        = hl0;
      if (tgt_vld) begin
         if (el >= {16'd0, superlong_hold_ff} && hl0 < LVL_SUPERLONG) begin
            hold_fire = 1'b1;
            hold_code = EV_SUPERLONG;
            hl1       = LVL_SUPERLONG;
         end else if (el >= {16'd0, verylong_hold_ff} && hl0 < LVL_VERYLONG) begin
            hold_fire = 1'b1;
            hold_code = EV_VERYLONG;
            hl1       = LVL_VERYLONG;
         end else if (el >= {16'd0, long_hold_ff} && hl0 < LVL_LONG) begin
            hold_fire = 1'b1;
            hold_code = EV_LONG;
            hl1       = LVL_LONG;
         end else if (el >= {16'd0, short_hold_ff} && hl0 < LVL_SHORT) begin
            hold_fire  = 1'b1;
            short_fire = 1'b1;
            hold_code  = EV_SHORT;
            hl1        = LVL_SHORT;
         end
      end

      // auto-repeat for up and down
      rate     = (hl1 >= LVL_LONG) ? fast_repeat_ff : slow_repeat_ff;
      rdiff    = short_fire ? 32'd0 : rep_elapsed;
      rep_fire = tgt_vld && tgt_idx >= BTN_UP && hl1 >= LVL_SHORT &&
                 rdiff >= {16'd0, rate};

      case (in_func_ff)
         FUNC_STOP: begin
            hold_in = LVL_STOPPED;
         end
         FUNC_ACTIVITY: begin
            activity_in = in_now_ff;
         end
         FUNC_POLL: begin
            if (!debounced) begin
               // event list in emission order
               if (rel && hold_ff < LVL_STOPPED) begin
                  ev_list[ev_n[1:0]] = '{button: act_idx, event_res: EV_RELEASE,
                                         prior_level: hold_ff};
                  ev_n = ev_n + 3'd1;
               end
               if (press) begin
                  ev_list[ev_n[1:0]] = '{button: press_idx, event_res: EV_PRESS,
                                         prior_level: LVL_NONE};
                  ev_n = ev_n + 3'd1;
               end
               if (hold_fire) begin
                  ev_list[ev_n[1:0]] = '{button: tgt_idx, event_res: hold_code,
                                         prior_level: hl0};
                  ev_n = ev_n + 3'd1;
               end
               if (rep_fire) begin
                  ev_list[ev_n[1:0]] = '{button: tgt_idx, event_res: EV_PRESS,
                                         prior_level: hl1};
                  ev_n = ev_n + 3'd1;
               end
               // next state
               if (press) begin
                  active_in   = {1'b0, press_idx} + 3'd1;
                  activity_in = in_now_ff;
               end else if (rel) begin
                  active_in = ACT_NONE;
               end
               if (tgt_vld) begin
                  hold_in = hl1;
               end else if (rel) begin
                  hold_in = LVL_NONE;
               end
               if (short_fire || rep_fire) begin
                  repeat_in = in_now_ff;
               end
            end
         end
         default: ;
      endcase
   end

   // state update on each classified item
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= ACT_NONE;
         hold_ff     <= LVL_NONE;
         activity_ff <= 32'd0;
         repeat_ff   <= 32'd0;
      end else if (proc) begin
         active_ff   <= active_in;
         hold_ff     <= hold_in;
         activity_ff <= activity_in;
         repeat_ff   <= repeat_in;
      end
   end

   // result buffer: load on classify, drain one beat per cycle while rsp is ready
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 3'd0;
         rd_ff  <= 2'd0;
      end else if (proc) begin
         rem_ff <= ev_n;
         rd_ff  <= 2'd0;
      end else if (rsp_tvalid && rsp_tready) begin
         rem_ff <= rem_ff - 3'd1;
         rd_ff  <= rd_ff + 2'd1;
      end
      if (proc) begin
         for (int i = 0; i < 4; i++) ev_ff[i] <= ev_list[i];
      end
   end

   // result beat
   assign cur_ev    = ev_ff[rd_ff];
   assign rsp_tdata = {7'd0, cur_ev.prior_level, cur_ev.event_res, cur_ev.button};
   assign rsp_tlast = rem_ff == 3'd1;

   // checks
   a_hold_code: assert property (@(posedge clock) disable iff (reset)
      hold_ff == LVL_NONE || hold_ff == LVL_SHORT || hold_ff == LVL_LONG ||
      hold_ff == LVL_VERYLONG || hold_ff == LVL_SUPERLONG || hold_ff == LVL_STOPPED)
      else $error("hold level holds an unused code");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      active_ff == ACT_NONE |-> (hold_ff == LVL_NONE || hold_ff == LVL_STOPPED))
      else $error("hold level left over with no active button");

   a_load: assert property (@(posedge clock) disable iff (reset)
      proc && ev_n != 3'd0 |=> rsp_tvalid && rd_ff == 2'd0)
      else $error("classified events not offered from the buffer head");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= 3'd4 && ({1'b0, rd_ff} + rem_ff) <= 3'd4)
      else $error("result buffer count out of range");

endmodule
